/* hdl/pla_pkg.sv */
`timescale 1ns / 1ps

package pla_pkg;

	localparam int CHANNELS  = 8;
	localparam int CH_W      = 3;
	localparam int MAX_BATCH = 4096;
	localparam int CNT_W     = $clog2(MAX_BATCH + 1);
	localparam int DATA_W    = 32;
	localparam int GAIN_W    = 24;
	localparam int SUM_W     = DATA_W + $clog2(MAX_BATCH);
	localparam int REM_W     = CNT_W + 1;
	localparam int STEP_W    = $clog2(SUM_W);
	localparam int IDX_W     = 3;

	localparam int IN_BITS  = CH_W + 2 * DATA_W;
	localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_BITS = CH_W + 3 * DATA_W;
	localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

	localparam logic [IDX_W-1:0] REG_GAIN_P      = 3'd0;
	localparam logic [IDX_W-1:0] REG_GAIN_I      = 3'd1;
	localparam logic [IDX_W-1:0] REG_GAIN_D      = 3'd2;
	localparam logic [IDX_W-1:0] REG_ALPHA_LIMIT = 3'd3;
	localparam logic [IDX_W-1:0] REG_START_ALPHA = 3'd4;

	localparam logic [DATA_W-1:0] LIMIT_RESET = 32'd65536;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_DIV,
		ST_FIX,
		ST_MUL,
		ST_INTEG,
		ST_ALPHA
	} pla_state_t;

	typedef struct packed {
		logic accum;
		logic load;
		logic step;
		logic fix;
		logic mul;
		logic integ;
		logic commit;
	} pla_cmd_t;

	typedef struct packed {
		logic ch_ok;
		logic out_free;
	} pla_stat_t;

endpackage

/* hdl/pla_ctrl.sv */
`timescale 1ns / 1ps

module pla_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	input  logic               s_tlast,
	input  pla_pkg::pla_stat_t stat,
	output logic               s_tready,
	output pla_pkg::pla_cmd_t  cmd
);
	import pla_pkg::*;

	pla_state_t        state_q;
	pla_state_t        state_d;
	logic [STEP_W-1:0] step_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_LOAD) begin
				step_q <= '0;
			end else if (state_q == ST_DIV) begin
				step_q <= step_q + 1'b1;
			end
		end
	end

	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		cmd      = '0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid && stat.ch_ok) begin
					cmd.accum = 1'b1;
					if (s_tlast) begin
						state_d = ST_LOAD;
					end
				end
			end
			ST_LOAD: begin
				cmd.load = 1'b1;
				state_d  = ST_DIV;
			end
			ST_DIV: begin
				cmd.step = 1'b1;
				if (step_q == STEP_W'(SUM_W - 1)) begin
					state_d = ST_FIX;
				end
			end
			ST_FIX: begin
				cmd.fix = 1'b1;
				state_d = ST_MUL;
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_INTEG;
			end
			ST_INTEG: begin
				cmd.integ = 1'b1;
				state_d   = ST_ALPHA;
			end
			ST_ALPHA: begin
				if (stat.out_free) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

/* hdl/pla_datapath.sv */
`timescale 1ns / 1ps

module pla_datapath (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [pla_pkg::IDX_W-1:0]  cfg_index,
	input  logic [pla_pkg::DATA_W-1:0] cfg_data,
	input  logic [pla_pkg::IN_W-1:0]   s_tdata,
	input  logic                       m_tready,
	input  pla_pkg::pla_cmd_t          cmd,
	output pla_pkg::pla_stat_t         stat,
	output logic                       m_tvalid,
	output logic [pla_pkg::OUT_W-1:0]  m_tdata
);
	import pla_pkg::*;

	localparam int PI_W  = GAIN_W + 1 + DATA_W;
	localparam int PD_W  = GAIN_W + 1 + DATA_W + 1;
	localparam int TI_W  = PI_W - 16;
	localparam int TD_W  = PD_W - 16;
	localparam int INT_W = TI_W + 2;
	localparam int A_W   = TD_W + 2;

	logic [CH_W-1:0]          in_ch;
	logic signed [DATA_W-1:0] in_ent;
	logic signed [DATA_W-1:0] in_tgt;
	logic signed [DATA_W:0]   err_wide;
	logic signed [DATA_W-1:0] err_sat;

	logic [GAIN_W-1:0] gain_p_q;
	logic [GAIN_W-1:0] gain_i_q;
	logic [GAIN_W-1:0] gain_d_q;
	logic [DATA_W-1:0] limit_q;
	logic [DATA_W-1:0] start_clamped;

	logic signed [SUM_W-1:0]  ent_sum_q [CHANNELS];
	logic signed [SUM_W-1:0]  err_sum_q [CHANNELS];
	logic [CNT_W-1:0]         cnt_q     [CHANNELS];
	logic signed [DATA_W-1:0] prev_q    [CHANNELS];
	logic [DATA_W-1:0]        integ_st_q[CHANNELS];
	logic [CHANNELS-1:0]      seen_q;

	logic [CH_W-1:0]  ch_q;
	logic             ent_neg_q;
	logic             err_neg_q;
	logic [SUM_W-1:0] ent_dvd_q;
	logic [SUM_W-1:0] err_dvd_q;
	logic [REM_W-1:0] ent_rem_q;
	logic [REM_W-1:0] err_rem_q;
	logic [CNT_W-1:0] divisor_q;

	logic [REM_W-1:0] ent_rem_sh;
	logic [REM_W-1:0] err_rem_sh;
	logic             ent_ge;
	logic             err_ge;

	logic signed [DATA_W-1:0] mean_q;
	logic signed [DATA_W-1:0] errm_q;
	logic signed [GAIN_W:0]   gp_s;
	logic signed [GAIN_W:0]   gi_s;
	logic signed [GAIN_W:0]   gd_s;
	logic signed [DATA_W:0]   deriv;
	logic signed [PI_W-1:0]   prod_p_q;
	logic signed [PI_W-1:0]   prod_i_q;
	logic signed [PD_W-1:0]   prod_d_q;

	logic signed [INT_W-1:0]  integ_sum;
	logic signed [INT_W-1:0]  limit_int;
	logic [DATA_W-1:0]        integ_q;
	logic signed [TI_W-1:0]   pterm_q;
	logic signed [TD_W-1:0]   dterm_q;

	logic signed [A_W-1:0]    alpha_sum;
	logic signed [A_W-1:0]    limit_a;
	logic [DATA_W-1:0]        alpha;

	logic                     out_valid_q;
	logic [OUT_BITS-1:0]      out_data_q;

	assign in_ch  = s_tdata[CH_W-1:0];
	assign in_ent = s_tdata[CH_W +: DATA_W];
	assign in_tgt = s_tdata[CH_W + DATA_W +: DATA_W];

	assign err_wide = {in_tgt[DATA_W-1], in_tgt} - {in_ent[DATA_W-1], in_ent};
	always_comb begin
		if (err_wide[DATA_W] != err_wide[DATA_W-1]) begin
			err_sat = err_wide[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
		end else begin
			err_sat = err_wide[DATA_W-1:0];
		end
	end

	assign start_clamped = (cfg_data < limit_q) ? cfg_data : limit_q;

	assign stat.ch_ok    = (int'(in_ch) < CHANNELS);
	assign stat.out_free = !out_valid_q || m_tready;

	assign ent_rem_sh = {ent_rem_q[REM_W-2:0], ent_dvd_q[SUM_W-1]};
	assign err_rem_sh = {err_rem_q[REM_W-2:0], err_dvd_q[SUM_W-1]};
	assign ent_ge     = (ent_rem_sh >= {1'b0, divisor_q});
	assign err_ge     = (err_rem_sh >= {1'b0, divisor_q});

	assign gp_s  = {1'b0, gain_p_q};
	assign gi_s  = {1'b0, gain_i_q};
	assign gd_s  = {1'b0, gain_d_q};
	assign deriv = seen_q[ch_q] ? ({prev_q[ch_q][DATA_W-1], prev_q[ch_q]} -
	               {mean_q[DATA_W-1], mean_q}) : '0;

	assign limit_int = INT_W'({1'b0, limit_q});
	assign integ_sum = INT_W'(signed'({1'b0, integ_st_q[ch_q]})) +
	                   INT_W'(signed'(prod_i_q[PI_W-1:16]));

	assign limit_a   = A_W'({1'b0, limit_q});
	assign alpha_sum = A_W'(pterm_q) + A_W'(signed'({1'b0, integ_q})) + A_W'(dterm_q);

	always_comb begin
		if (alpha_sum < 0) begin
			alpha = '0;
		end else if (alpha_sum > limit_a) begin
			alpha = limit_q;
		end else begin
			alpha = alpha_sum[DATA_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_p_q <= '0;
			gain_i_q <= '0;
			gain_d_q <= '0;
			limit_q  <= LIMIT_RESET;
			seen_q   <= '0;
			for (int c = 0; c < CHANNELS; c++) begin
				ent_sum_q[c]  <= '0;
				err_sum_q[c]  <= '0;
				cnt_q[c]      <= '0;
				prev_q[c]     <= '0;
				integ_st_q[c] <= '0;
			end
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_GAIN_P:      gain_p_q <= cfg_data[GAIN_W-1:0];
					REG_GAIN_I:      gain_i_q <= cfg_data[GAIN_W-1:0];
					REG_GAIN_D:      gain_d_q <= cfg_data[GAIN_W-1:0];
					REG_ALPHA_LIMIT: limit_q  <= cfg_data;
					REG_START_ALPHA: begin
						for (int c = 0; c < CHANNELS; c++) begin
							integ_st_q[c] <= start_clamped;
						end
					end
					default: begin
					end
				endcase
			end
			if (cmd.accum && (cnt_q[in_ch] < CNT_W'(MAX_BATCH))) begin
				ent_sum_q[in_ch] <= ent_sum_q[in_ch] + SUM_W'(in_ent);
				err_sum_q[in_ch] <= err_sum_q[in_ch] + SUM_W'(err_sat);
				cnt_q[in_ch]     <= cnt_q[in_ch] + 1'b1;
			end
			if (cmd.commit) begin
				integ_st_q[ch_q] <= integ_q;
				prev_q[ch_q]     <= mean_q;
				seen_q[ch_q]     <= 1'b1;
				ent_sum_q[ch_q]  <= '0;
				err_sum_q[ch_q]  <= '0;
				cnt_q[ch_q]      <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accum) begin
			ch_q <= in_ch;
		end
		if (cmd.load) begin
			ent_neg_q <= ent_sum_q[ch_q][SUM_W-1];
			err_neg_q <= err_sum_q[ch_q][SUM_W-1];
			ent_dvd_q <= ent_sum_q[ch_q][SUM_W-1] ? -ent_sum_q[ch_q] : ent_sum_q[ch_q];
			err_dvd_q <= err_sum_q[ch_q][SUM_W-1] ? -err_sum_q[ch_q] : err_sum_q[ch_q];
			ent_rem_q <= '0;
			err_rem_q <= '0;
			divisor_q <= (cnt_q[ch_q] == '0) ? CNT_W'(1) : cnt_q[ch_q];
		end
		if (cmd.step) begin
			ent_rem_q <= ent_ge ? (ent_rem_sh - {1'b0, divisor_q}) : ent_rem_sh;
			err_rem_q <= err_ge ? (err_rem_sh - {1'b0, divisor_q}) : err_rem_sh;
			ent_dvd_q <= {ent_dvd_q[SUM_W-2:0], ent_ge};
			err_dvd_q <= {err_dvd_q[SUM_W-2:0], err_ge};
		end
		if (cmd.fix) begin
			mean_q <= ent_neg_q ? -ent_dvd_q[DATA_W-1:0] : ent_dvd_q[DATA_W-1:0];
			errm_q <= err_neg_q ? -err_dvd_q[DATA_W-1:0] : err_dvd_q[DATA_W-1:0];
		end
		if (cmd.mul) begin
			prod_p_q <= PI_W'(gp_s * errm_q);
			prod_i_q <= PI_W'(gi_s * errm_q);
			prod_d_q <= PD_W'(gd_s * deriv);
		end
		if (cmd.integ) begin
			if (integ_sum < 0) begin
				integ_q <= '0;
			end else if (integ_sum > limit_int) begin
				integ_q <= limit_q;
			end else begin
				integ_q <= integ_sum[DATA_W-1:0];
			end
			pterm_q <= prod_p_q[PI_W-1:16];
			dterm_q <= prod_d_q[PD_W-1:16];
		end
		if (cmd.commit) begin
			out_data_q <= {mean_q, integ_q, alpha, ch_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(OUT_W - OUT_BITS){1'b0}}, out_data_q};

endmodule

/* hdl/pid_lagrangian_alpha_unit.sv */
// A word with tlast set on a valid channel gives a result when its update commits; other words give none.
// Throughput: words without tlast are accepted one per cycle; after a tlast word on a valid channel the
// input stalls for the 44-step restoring divider, the gain multiplies, the clamps and a free output register.
// The output register holds a result while the next batch is accepted.
// Reset clears all sums, counts, previous means and first-update flags, loads the gains with 0,
// the limit with 1.0 and every integral with 0.
`timescale 1ns / 1ps

module pid_lagrangian_alpha_unit (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [pla_pkg::IDX_W-1:0]  cfg_index,
	input  logic [pla_pkg::DATA_W-1:0] cfg_data,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [pla_pkg::IN_W-1:0]   s_tdata,  // channel, entropy, target
	input  logic                       s_tlast,
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [pla_pkg::OUT_W-1:0]  m_tdata   // out_channel, alpha, integral_value, batch_mean
);
	import pla_pkg::*;

	pla_cmd_t  cmd;
	pla_stat_t stat;

	pla_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tlast  (s_tlast),
		.stat     (stat),
		.s_tready (s_tready),
		.cmd      (cmd)
	);

	pla_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tdata   (s_tdata),
		.m_tready  (m_tready),
		.cmd       (cmd),
		.stat      (stat),
		.m_tvalid  (m_tvalid),
		.m_tdata   (m_tdata)
	);

endmodule

/* hdl/pla_checker.sv */
`timescale 1ns / 1ps

module pla_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      s_tvalid,
	input logic                      s_tready,
	input logic                      s_tlast,
	input logic                      m_tvalid,
	input logic                      m_tready,
	input logic [pla_pkg::OUT_W-1:0] m_tdata
);
	import pla_pkg::*;

	// A word held on the output stays until it is taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output word changed or dropped while stalled");

	// The end of a batch starts the update, so the input closes.
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tlast |=> !s_tready)
		else $error("input still open after a batch end");

	// A word inside a batch leaves the input open for the next one.
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && !s_tlast |=> s_tready)
		else $error("input closed after a word inside a batch");

	// A new result appears only at the end of an update, while the input is closed.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(!s_tready))
		else $error("result appeared without an update");

endmodule

bind pid_lagrangian_alpha_unit pla_checker u_pla_checker (.*);
